/* hw/rtl/rcbd_pkg.sv */
// Shared widths, constants and register indexes of the contention backoff delay block.
package rcbd_pkg;

  localparam int unsigned MAX_SPREAD_FACTOR = 20;

  localparam int unsigned SF_W    = 5;
  localparam int unsigned BW_W    = 21;
  localparam int unsigned UTIL_W  = 8;
  localparam int unsigned SNR_W   = 8;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned EXP_W   = 4;
  localparam int unsigned MULT_W  = 8;
  localparam int unsigned OVR_W   = 16;
  localparam int unsigned SLOT_W  = 23;
  localparam int unsigned DELAY_W = 32;

  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_MIN  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_MAX  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_RELAY_MULT  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SLOT_OVR    = CFG_IDX_W'(3);

  localparam logic [EXP_W-1:0]  WINDOW_MIN_RST = EXP_W'(3);
  localparam logic [EXP_W-1:0]  WINDOW_MAX_RST = EXP_W'(8);
  localparam logic [MULT_W-1:0] RELAY_MULT_RST = MULT_W'(1);
  localparam logic [OVR_W-1:0]  SLOT_OVR_RST   = OVR_W'(0);

  // Bandwidth in kHz by reciprocal multiplication (exact for 21-bit inputs).
  localparam int unsigned KHZ_W       = 12;
  localparam int unsigned KHZ_SHIFT   = 31;
  localparam int unsigned KHZ_RECIP_W = 22;
  localparam logic [KHZ_RECIP_W-1:0] KHZ_RECIP = KHZ_RECIP_W'(2147484);
  localparam int unsigned KHZ_PROD_W  = BW_W + KHZ_RECIP_W;

  localparam int unsigned CAD_W         = 10;
  localparam int unsigned SUB_GHZ_CAD   = 225;
  localparam int unsigned CAD_SUB_GHZ   = (SUB_GHZ_CAD > 250) ? SUB_GHZ_CAD : 250;
  localparam int unsigned CAD_WIDE_BASE = 400;
  localparam int unsigned CAD_WIDE_STEP = 100;

  // Long division pipeline.
  localparam int unsigned DIV_NUM_W          = 32;
  localparam int unsigned DIV_DEN_W          = KHZ_W;
  localparam int unsigned DIV_BITS_PER_STAGE = 4;
  localparam int unsigned DIV_STAGES         = DIV_NUM_W / DIV_BITS_PER_STAGE;

  // Slot in ms from hundredths: (x + 760) / 100 by reciprocal multiplication.
  localparam int unsigned HUNDREDTHS_BIAS = 760;
  localparam int unsigned SLOT_X_W        = 30;
  localparam int unsigned SLOT_RECIP_W    = 31;
  localparam logic [SLOT_RECIP_W-1:0] SLOT_RECIP = SLOT_RECIP_W'(1374389535);
  localparam int unsigned SLOT_SHIFT      = 37;
  localparam int unsigned SLOT_PROD_W     = SLOT_X_W + SLOT_RECIP_W;

  // Utilisation map: util * span / 100.
  localparam int unsigned UTIL_MAX     = 100;
  localparam int unsigned UTIL_C_W     = 7;
  localparam int unsigned OWN_PROD_W   = 11;
  localparam int unsigned OWN_RECIP    = 1311;
  localparam int unsigned OWN_SHIFT    = 17;
  localparam int unsigned OWN_QPROD_W  = 22;

  // SNR map: (snr + 20) * span / 30, truncated toward zero.
  localparam int          SNR_LOW      = -20;
  localparam int unsigned SNR_OFF_W    = SNR_W + 1;
  localparam int unsigned SNR_MAG_W    = 8;
  localparam int unsigned REL_PROD_W   = 12;
  localparam int unsigned RELAY_RECIP  = 2185;
  localparam int unsigned RELAY_SHIFT  = 16;
  localparam int unsigned REL_QPROD_W  = 24;
  localparam int unsigned REL_Q_W      = 7;

  localparam int unsigned DRAW_W       = 15;
  localparam int unsigned OFFSET_W     = MULT_W + EXP_W;

endpackage

/* hw/rtl/rcbd_div_pipe.sv */
// Pipelined restoring divider giving quotient and remainder, four bits per stage.
module rcbd_div_pipe (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic [rcbd_pkg::DIV_NUM_W-1:0]   num_i,
  input  logic [rcbd_pkg::DIV_DEN_W-1:0]   den_i,
  output logic [rcbd_pkg::DIV_NUM_W-1:0]   quot_o,
  output logic [rcbd_pkg::DIV_DEN_W-1:0]   rem_o
);
  import rcbd_pkg::*;

  typedef struct packed {
    logic [DIV_NUM_W-1:0] acc;
    logic [DIV_DEN_W-1:0] rem;
    logic [DIV_DEN_W-1:0] den;
  } div_stage_t;

  div_stage_t stage_in [DIV_STAGES];
  div_stage_t stage_d  [DIV_STAGES];
  div_stage_t stage_q  [DIV_STAGES];

  always_comb begin
    stage_in[0] = '{acc: num_i, rem: '0, den: den_i};
    for (int s = 1; s < DIV_STAGES; s++) begin
      stage_in[s] = stage_q[s-1];
    end
  end

  always_comb begin
    logic [DIV_DEN_W:0] trial;
    trial = '0;
    for (int s = 0; s < DIV_STAGES; s++) begin
      stage_d[s] = stage_in[s];
      for (int b = 0; b < DIV_BITS_PER_STAGE; b++) begin
        trial = {stage_d[s].rem, stage_d[s].acc[DIV_NUM_W-1]};
        stage_d[s].acc = {stage_d[s].acc[DIV_NUM_W-2:0], 1'b0};
        if (trial >= {1'b0, stage_d[s].den}) begin
          trial = trial - {1'b0, stage_d[s].den};
          stage_d[s].acc[0] = 1'b1;
        end
        stage_d[s].rem = trial[DIV_DEN_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < DIV_STAGES; s++) begin
        stage_q[s] <= stage_d[s];
      end
    end
  end

  assign quot_o = stage_q[DIV_STAGES-1].acc;
  assign rem_o  = stage_q[DIV_STAGES-1].rem;

  logic unused_rst;
  assign unused_rst = rst_ni;

endmodule

/* hw/rtl/radio_contention_backoff_delay.sv */
// Top level of the contention window backoff delay pipeline.
//
//   channel | signals                              | direction
//   --------+--------------------------------------+----------
//   in      | in_valid_i, in_ready_o, request      | to block
//   out     | out_valid_o, out_ready_i, result     | from block
//   cfg     | cfg_valid_i, cfg_ready_o, index/data | to block
//
// One request is taken per cycle while no result waits untaken at the output.
// The pipeline is made of the divider for the slot time, eight stages of four
// quotient bits each, plus six stages of mapping, scaling and multiplication.
// Reset clears all valid bits and loads the register defaults 3, 8, 1 and 0.
// When a result waits untaken, every stage holds and in_ready_o is low.
module radio_contention_backoff_delay (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [rcbd_pkg::SF_W-1:0]          spread_factor_i,
  input  logic [rcbd_pkg::BW_W-1:0]          bandwidth_hz_i,
  input  logic                               wide_band_i,
  input  logic [rcbd_pkg::UTIL_W-1:0]        utilisation_pct_i,
  input  logic signed [rcbd_pkg::SNR_W-1:0]  link_snr_i,
  input  logic                               router_like_i,
  input  logic [rcbd_pkg::WORD_W-1:0]        own_random_i,
  input  logic [rcbd_pkg::WORD_W-1:0]        relay_random_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [rcbd_pkg::SLOT_W-1:0]        slot_ms_o,
  output logic [rcbd_pkg::EXP_W-1:0]         own_window_exp_o,
  output logic [rcbd_pkg::EXP_W-1:0]         relay_window_exp_o,
  output logic [rcbd_pkg::DELAY_W-1:0]       own_delay_ms_o,
  output logic [rcbd_pkg::DELAY_W-1:0]       relay_delay_ms_o,
  output logic [rcbd_pkg::DELAY_W-1:0]       relay_worst_ms_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [rcbd_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [rcbd_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import rcbd_pkg::*;

  localparam int unsigned DRAW_PROD_W = DRAW_W + SLOT_W;
  localparam int unsigned OFF_PROD_W  = OFFSET_W + SLOT_W;

  typedef struct packed {
    logic [KHZ_W-1:0]      khz;
    logic [DIV_NUM_W-1:0]  num;
    logic                  bad_sf;
    logic [OWN_PROD_W-1:0] own_prod;
    logic [REL_PROD_W-1:0] rel_prod;
    logic                  rel_neg;
    logic                  router;
    logic [WORD_W-1:0]     own_word;
    logic [WORD_W-1:0]     relay_word;
  } s1_t;

  typedef struct packed {
    logic              bad;
    logic [EXP_W-1:0]  own_exp;
    logic [EXP_W-1:0]  relay_exp;
    logic              router;
    logic [WORD_W-1:0] own_word;
    logic [WORD_W-1:0] relay_word;
  } side_t;

  typedef struct packed {
    logic [SLOT_PROD_W-1:0] prod;
    logic                   bad;
    logic [EXP_W-1:0]       own_exp;
    logic [EXP_W-1:0]       relay_exp;
    logic                   router;
    logic [DRAW_W-1:0]      own_draw;
    logic [DRAW_W-1:0]      relay_draw;
  } s3_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [EXP_W-1:0]  own_exp;
    logic [EXP_W-1:0]  relay_exp;
    logic              router;
    logic [DRAW_W-1:0] own_draw;
    logic [DRAW_W-1:0] relay_draw;
  } s4_t;

  typedef struct packed {
    logic [SLOT_W-1:0]  slot;
    logic [EXP_W-1:0]   own_exp;
    logic [EXP_W-1:0]   relay_exp;
    logic               router;
    logic [DELAY_W-1:0] own_d;
    logic [DELAY_W-1:0] rel_d;
    logic [DELAY_W-1:0] off_d;
    logic [DELAY_W-1:0] pow_d;
  } s5_t;

  function automatic logic [DRAW_W-1:0] draw_mask(input logic [EXP_W-1:0] e);
    logic [DRAW_W:0] p;
    p = (DRAW_W + 1)'(1) << e;
    p = p - (DRAW_W + 1)'(1);
    return p[DRAW_W-1:0];
  endfunction

  // Configuration registers.
  logic [EXP_W-1:0]    cfg_min_q, cfg_max_q;
  logic [MULT_W-1:0]   cfg_mult_q;
  logic [OVR_W-1:0]    cfg_ovr_q;
  logic [EXP_W-1:0]    win_lo, win_hi, win_span;
  logic [OFFSET_W-1:0] offset_q;

  assign cfg_ready_o = 1'b1;
  assign win_lo      = cfg_min_q;
  assign win_hi      = (cfg_max_q < cfg_min_q) ? cfg_min_q : cfg_max_q;
  assign win_span    = win_hi - win_lo;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_min_q  <= WINDOW_MIN_RST;
      cfg_max_q  <= WINDOW_MAX_RST;
      cfg_mult_q <= RELAY_MULT_RST;
      cfg_ovr_q  <= SLOT_OVR_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_WINDOW_MIN: cfg_min_q  <= cfg_data_i[EXP_W-1:0];
        REG_WINDOW_MAX: cfg_max_q  <= cfg_data_i[EXP_W-1:0];
        REG_RELAY_MULT: cfg_mult_q <= cfg_data_i[MULT_W-1:0];
        REG_SLOT_OVR:   cfg_ovr_q  <= cfg_data_i[OVR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    offset_q <= OFFSET_W'(cfg_mult_q) * OFFSET_W'(win_hi);
  end

  // Pipeline control.
  logic adv;
  logic v1_q, v2_q, v3_q, v4_q, v5_q, vout_q;
  logic [DIV_STAGES-1:0] vside_q;

  assign adv        = !vout_q || out_ready_i;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      vside_q <= '0;
      v3_q    <= 1'b0;
      v4_q    <= 1'b0;
      v5_q    <= 1'b0;
      vout_q  <= 1'b0;
    end else if (adv) begin
      v1_q    <= in_valid_i;
      v2_q    <= v1_q;
      vside_q <= {vside_q[DIV_STAGES-2:0], v2_q};
      v3_q    <= vside_q[DIV_STAGES-1];
      v4_q    <= v3_q;
      v5_q    <= v4_q;
      vout_q  <= v5_q;
    end
  end

  // Stage 1: bandwidth in kHz, CAD numerator and the two map products.
  s1_t s1_d, s1_q;
  logic [KHZ_PROD_W-1:0]  khz_prod;
  logic [SF_W+1:0]        cad_sel;
  logic [CAD_W-1:0]       cad;
  logic [UTIL_C_W-1:0]    util_c;
  logic signed [SNR_OFF_W-1:0] snr_off;
  logic [SNR_MAG_W-1:0]   snr_mag;

  always_comb begin
    khz_prod = KHZ_PROD_W'(bandwidth_hz_i) * KHZ_PROD_W'(KHZ_RECIP);
    cad_sel  = {1'b0, spread_factor_i, 1'b0} + (SF_W + 2)'(3);
    cad      = wide_band_i
             ? CAD_W'(CAD_WIDE_BASE) + CAD_W'(CAD_WIDE_STEP) * CAD_W'(cad_sel[SF_W+1:SF_W])
             : CAD_W'(CAD_SUB_GHZ);
    util_c   = (utilisation_pct_i > UTIL_W'(UTIL_MAX)) ? UTIL_C_W'(UTIL_MAX)
                                                       : utilisation_pct_i[UTIL_C_W-1:0];
    snr_off  = SNR_OFF_W'(link_snr_i) + SNR_OFF_W'(-SNR_LOW);
    snr_mag  = snr_off[SNR_OFF_W-1] ? SNR_MAG_W'(-snr_off) : SNR_MAG_W'(snr_off);

    s1_d.khz        = khz_prod[KHZ_SHIFT +: KHZ_W];
    s1_d.num        = DIV_NUM_W'(cad) << spread_factor_i;
    s1_d.bad_sf     = (spread_factor_i == '0) ||
                      (spread_factor_i > SF_W'(MAX_SPREAD_FACTOR));
    s1_d.own_prod   = OWN_PROD_W'(util_c) * OWN_PROD_W'(win_span);
    s1_d.rel_prod   = REL_PROD_W'(snr_mag) * REL_PROD_W'(win_span);
    s1_d.rel_neg    = snr_off[SNR_OFF_W-1];
    s1_d.router     = router_like_i;
    s1_d.own_word   = own_random_i;
    s1_d.relay_word = relay_random_i;
  end

  // Stage 2: window exponents and divider operands.
  side_t s2_d, s2_q;
  logic [KHZ_W-1:0]       khz2_q;
  logic [DIV_NUM_W-1:0]   num2_q;
  logic [OWN_QPROD_W-1:0] own_qprod;
  logic [REL_QPROD_W-1:0] rel_qprod;
  logic [EXP_W-1:0]       own_q;
  logic [REL_Q_W-1:0]     rel_q;

  always_comb begin
    own_qprod = OWN_QPROD_W'(s1_q.own_prod) * OWN_QPROD_W'(OWN_RECIP);
    rel_qprod = REL_QPROD_W'(s1_q.rel_prod) * REL_QPROD_W'(RELAY_RECIP);
    own_q     = own_qprod[OWN_SHIFT +: EXP_W];
    rel_q     = rel_qprod[RELAY_SHIFT +: REL_Q_W];

    s2_d.bad        = s1_q.bad_sf || (s1_q.khz == '0);
    s2_d.own_exp    = (own_q >= win_span) ? win_hi : win_lo + own_q;
    if (s1_q.rel_neg) begin
      s2_d.relay_exp = win_lo;
    end else if (rel_q >= REL_Q_W'(win_span)) begin
      s2_d.relay_exp = win_hi;
    end else begin
      s2_d.relay_exp = win_lo + rel_q[EXP_W-1:0];
    end
    s2_d.router     = s1_q.router;
    s2_d.own_word   = s1_q.own_word;
    s2_d.relay_word = s1_q.relay_word;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q   <= s1_d;
      s2_q   <= s2_d;
      khz2_q <= s1_q.khz;
      num2_q <= s1_q.num;
    end
  end

  // Divider stages: slot hundredths and the router window draw.
  logic [DIV_NUM_W-1:0] slot_quot, rel_quot;
  logic [DIV_DEN_W-1:0] slot_rem, rel_rem;
  side_t side_q [DIV_STAGES];

  rcbd_div_pipe u_slot_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .num_i  (num2_q),
    .den_i  (khz2_q),
    .quot_o (slot_quot),
    .rem_o  (slot_rem)
  );

  rcbd_div_pipe u_relay_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .num_i  (s2_q.relay_word),
    .den_i  (DIV_DEN_W'({s2_q.relay_exp, 1'b0})),
    .quot_o (rel_quot),
    .rem_o  (rel_rem)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_q[0] <= s2_q;
      for (int k = 1; k < DIV_STAGES; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // Stage 3: reciprocal product for the slot and the random draws.
  s3_t   s3_d, s3_q;
  side_t sd;
  logic [SLOT_X_W-1:0] slot_x;

  always_comb begin
    sd     = side_q[DIV_STAGES-1];
    slot_x = SLOT_X_W'(slot_quot) + SLOT_X_W'(HUNDREDTHS_BIAS);
    s3_d.prod      = SLOT_PROD_W'(slot_x) * SLOT_PROD_W'(SLOT_RECIP);
    s3_d.bad       = sd.bad;
    s3_d.own_exp   = sd.own_exp;
    s3_d.relay_exp = sd.relay_exp;
    s3_d.router    = sd.router;
    s3_d.own_draw  = sd.own_word[DRAW_W-1:0] & draw_mask(sd.own_exp);
    if (!sd.router) begin
      s3_d.relay_draw = sd.relay_word[DRAW_W-1:0] & draw_mask(sd.relay_exp);
    end else if (sd.relay_exp == '0) begin
      s3_d.relay_draw = '0;
    end else begin
      s3_d.relay_draw = DRAW_W'(rel_rem);
    end
  end

  // Stage 4: slot selection.
  s4_t s4_d, s4_q;

  always_comb begin
    if (cfg_ovr_q != '0) begin
      s4_d.slot = SLOT_W'(cfg_ovr_q);
    end else if (s3_q.bad) begin
      s4_d.slot = '0;
    end else begin
      s4_d.slot = s3_q.prod[SLOT_SHIFT +: SLOT_W];
    end
    s4_d.own_exp    = s3_q.own_exp;
    s4_d.relay_exp  = s3_q.relay_exp;
    s4_d.router     = s3_q.router;
    s4_d.own_draw   = s3_q.own_draw;
    s4_d.relay_draw = s3_q.relay_draw;
  end

  // Stage 5: products with the slot time.
  s5_t s5_d, s5_q;
  logic [DRAW_PROD_W-1:0] own_p, rel_p, pow_p;
  logic [OFF_PROD_W-1:0]  off_p;

  always_comb begin
    own_p = DRAW_PROD_W'(s4_q.own_draw) * DRAW_PROD_W'(s4_q.slot);
    rel_p = DRAW_PROD_W'(s4_q.relay_draw) * DRAW_PROD_W'(s4_q.slot);
    pow_p = DRAW_PROD_W'(s4_q.slot) << s4_q.relay_exp;
    off_p = OFF_PROD_W'(offset_q) * OFF_PROD_W'(s4_q.slot);
    s5_d.slot      = s4_q.slot;
    s5_d.own_exp   = s4_q.own_exp;
    s5_d.relay_exp = s4_q.relay_exp;
    s5_d.router    = s4_q.router;
    s5_d.own_d     = own_p[DELAY_W-1:0];
    s5_d.rel_d     = rel_p[DELAY_W-1:0];
    s5_d.pow_d     = pow_p[DELAY_W-1:0];
    s5_d.off_d     = off_p[DELAY_W-1:0];
  end

  // Stage 6: output register.
  logic [SLOT_W-1:0]  slot_q;
  logic [EXP_W-1:0]   own_exp_q, relay_exp_q;
  logic [DELAY_W-1:0] own_d_q, relay_d_q, worst_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_q        <= s3_d;
      s4_q        <= s4_d;
      s5_q        <= s5_d;
      slot_q      <= s5_q.slot;
      own_exp_q   <= s5_q.own_exp;
      relay_exp_q <= s5_q.relay_exp;
      own_d_q     <= s5_q.own_d;
      relay_d_q   <= s5_q.router ? s5_q.rel_d : s5_q.off_d + s5_q.rel_d;
      worst_q     <= s5_q.off_d + s5_q.pow_d;
    end
  end

  assign out_valid_o        = vout_q;
  assign slot_ms_o          = slot_q;
  assign own_window_exp_o   = own_exp_q;
  assign relay_window_exp_o = relay_exp_q;
  assign own_delay_ms_o     = own_d_q;
  assign relay_delay_ms_o   = relay_d_q;
  assign relay_worst_ms_o   = worst_q;

  logic unused_div;
  assign unused_div = ^{slot_rem, rel_quot};

  a_exp_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (own_window_exp_o >= win_lo) && (own_window_exp_o <= win_hi) &&
                    (relay_window_exp_o >= win_lo) && (relay_window_exp_o <= win_hi))
    else $error("window exponent outside the configured bounds");

  a_zero_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (slot_ms_o == '0)) |->
      (own_delay_ms_o == '0) && (relay_delay_ms_o == '0) && (relay_worst_ms_o == '0))
    else $error("nonzero delay with a zero slot time");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v5_q && out_valid_o && !out_ready_i) |=> v5_q && out_valid_o)
    else $error("pipeline moved while the output was stalled");

endmodule

/* tb/rcbd_checker.sv */
// Checker that predicts each backoff result from the accepted requests and compares it.
module rcbd_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  input  logic                               in_ready_i,
  input  logic [rcbd_pkg::SF_W-1:0]          spread_factor_i,
  input  logic [rcbd_pkg::BW_W-1:0]          bandwidth_hz_i,
  input  logic                               wide_band_i,
  input  logic [rcbd_pkg::UTIL_W-1:0]        utilisation_pct_i,
  input  logic signed [rcbd_pkg::SNR_W-1:0]  link_snr_i,
  input  logic                               router_like_i,
  input  logic [rcbd_pkg::WORD_W-1:0]        own_random_i,
  input  logic [rcbd_pkg::WORD_W-1:0]        relay_random_i,
  input  logic                               out_valid_i,
  input  logic                               out_ready_i,
  input  logic [rcbd_pkg::SLOT_W-1:0]        slot_ms_i,
  input  logic [rcbd_pkg::EXP_W-1:0]         own_window_exp_i,
  input  logic [rcbd_pkg::EXP_W-1:0]         relay_window_exp_i,
  input  logic [rcbd_pkg::DELAY_W-1:0]       own_delay_ms_i,
  input  logic [rcbd_pkg::DELAY_W-1:0]       relay_delay_ms_i,
  input  logic [rcbd_pkg::DELAY_W-1:0]       relay_worst_ms_i,
  input  logic                               cfg_valid_i,
  input  logic                               cfg_ready_i,
  input  logic [rcbd_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [rcbd_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output int unsigned                        fail_count_o,
  output int unsigned                        outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import rcbd_pkg::*;

  localparam int unsigned HZ_PER_KHZ        = 1000;
  localparam int unsigned CAD_NARROW        = 250;
  localparam int unsigned CAD_WIDE_FLOOR    = 4;
  localparam int unsigned CAD_WIDE_UNIT     = 100;
  localparam int unsigned CAD_SF_DIV        = 32;
  localparam int unsigned SLOT_BIAS         = 760;
  localparam int unsigned HUNDREDTHS_PER_MS = 100;
  localparam int          UTIL_CEIL         = 100;
  localparam int          SNR_FLOOR         = -20;
  localparam int          SNR_CEIL          = 10;

  typedef struct packed {
    logic [SLOT_W-1:0]  slot_ms;
    logic [EXP_W-1:0]   own_exp;
    logic [EXP_W-1:0]   relay_exp;
    logic [DELAY_W-1:0] own_delay;
    logic [DELAY_W-1:0] relay_delay;
    logic [DELAY_W-1:0] relay_worst;
  } backoff_t;

  logic [EXP_W-1:0]  win_min;
  logic [EXP_W-1:0]  win_max;
  logic [MULT_W-1:0] relay_mult;
  logic [OVR_W-1:0]  slot_ovr;
  backoff_t          backoff_q[$];
  int unsigned       mismatches = 0;

  function automatic logic [31:0] airtime_slot(input logic [SF_W-1:0] sf,
                                               input logic [BW_W-1:0] bw,
                                               input logic wide);
    logic [31:0] khz;
    logic [31:0] cad;
    logic [63:0] hundredths;
    if (sf == '0 || sf > MAX_SPREAD_FACTOR) return '0;
    khz = 32'(bw) / HZ_PER_KHZ;
    if (khz == '0) return '0;
    if (wide) begin
      cad = (CAD_WIDE_FLOOR + (2 * 32'(sf) + 3) / CAD_SF_DIV) * CAD_WIDE_UNIT;
    end else begin
      cad = CAD_NARROW;
    end
    hundredths = (64'd1 << sf) * 64'(cad) / 64'(khz);
    return 32'((hundredths + SLOT_BIAS) / HUNDREDTHS_PER_MS);
  endfunction

  // Linear map truncated toward zero, then clamped to the window bounds.
  function automatic logic [EXP_W-1:0] map_window(input int pos, input int span,
                                                  input int lo, input int hi);
    int m;
    m = pos * (hi - lo) / span + lo;
    if (m < lo) return EXP_W'(lo);
    if (m > hi) return EXP_W'(hi);
    return EXP_W'(m);
  endfunction

  function automatic backoff_t backoff_for(input logic [SF_W-1:0] sf,
                                           input logic [BW_W-1:0] bw,
                                           input logic wide,
                                           input logic [UTIL_W-1:0] util,
                                           input logic signed [SNR_W-1:0] snr,
                                           input logic router,
                                           input logic [WORD_W-1:0] own_word,
                                           input logic [WORD_W-1:0] relay_word);
    backoff_t    r;
    logic [31:0] slot;
    logic [31:0] offset;
    logic [31:0] router_span;
    int          lo;
    int          hi;
    int          util_c;
    lo = int'(win_min);
    hi = (win_max < win_min) ? int'(win_min) : int'(win_max);
    slot = (slot_ovr != '0) ? 32'(slot_ovr) : airtime_slot(sf, bw, wide);
    util_c = (int'(util) > UTIL_CEIL) ? UTIL_CEIL : int'(util);
    r.slot_ms = slot[SLOT_W-1:0];
    r.own_exp = map_window(util_c, UTIL_CEIL, lo, hi);
    r.relay_exp = map_window(int'(snr) - SNR_FLOOR, SNR_CEIL - SNR_FLOOR, lo, hi);
    offset = 32'(relay_mult) * 32'(hi);
    r.own_delay = (own_word % (32'd1 << r.own_exp)) * slot;
    if (router) begin
      router_span = 32'(r.relay_exp) * 2;
      r.relay_delay = (router_span == '0) ? '0 : (relay_word % router_span) * slot;
    end else begin
      r.relay_delay = offset * slot + (relay_word % (32'd1 << r.relay_exp)) * slot;
    end
    r.relay_worst = offset * slot + (32'd1 << r.relay_exp) * slot;
    return r;
  endfunction

  function automatic int unsigned field_differs(input string name, input logic [31:0] want,
                                                input logic [31:0] got);
    if (want === got) return 0;
    $error("%s: expected %0d, got %0d", name, want, got);
    return 1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    backoff_t want;
    if (!rst_ni) begin
      win_min       <= WINDOW_MIN_RST;
      win_max       <= WINDOW_MAX_RST;
      relay_mult    <= RELAY_MULT_RST;
      slot_ovr      <= SLOT_OVR_RST;
      backoff_q.delete();
      fail_count_o  <= 0;
      outstanding_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (backoff_q.size() == 0) begin
          $error("result transfer with no request outstanding: slot_ms %0d", slot_ms_i);
          mismatches++;
        end else begin
          want = backoff_q.pop_front();
          mismatches += field_differs("slot_ms", 32'(want.slot_ms), 32'(slot_ms_i));
          mismatches += field_differs("own_window_exp", 32'(want.own_exp),
                                      32'(own_window_exp_i));
          mismatches += field_differs("relay_window_exp", 32'(want.relay_exp),
                                      32'(relay_window_exp_i));
          mismatches += field_differs("own_delay_ms", want.own_delay, own_delay_ms_i);
          mismatches += field_differs("relay_delay_ms", want.relay_delay, relay_delay_ms_i);
          mismatches += field_differs("relay_worst_ms", want.relay_worst, relay_worst_ms_i);
        end
      end
      if (in_valid_i && in_ready_i) begin
        backoff_q.push_back(backoff_for(spread_factor_i, bandwidth_hz_i, wide_band_i,
                                        utilisation_pct_i, link_snr_i, router_like_i,
                                        own_random_i, relay_random_i));
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_WINDOW_MIN: begin
            win_min <= cfg_data_i[EXP_W-1:0];
          end
          REG_WINDOW_MAX: begin
            win_max <= cfg_data_i[EXP_W-1:0];
          end
          REG_RELAY_MULT: begin
            relay_mult <= cfg_data_i[MULT_W-1:0];
          end
          REG_SLOT_OVR: begin
            slot_ovr <= cfg_data_i[OVR_W-1:0];
          end
          default: begin
          end
        endcase
      end
      fail_count_o  <= mismatches;
      outstanding_o <= backoff_q.size();
    end
  end

endmodule

/* tb/radio_contention_backoff_delay_tb.sv */
// Stimulus, clock, reset and verdict for the contention backoff delay block.
module radio_contention_backoff_delay_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rcbd_pkg::*;

  localparam int unsigned HALF_PERIOD   = 10;
  localparam int unsigned RESET_CYCLES  = 8;
  localparam int unsigned PHASE_ITEMS   = 155;
  localparam int unsigned RANDOM_PHASES = 6;
  localparam int unsigned SETTLE_CYCLES = 24;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned REG_COUNT     = 4;
  localparam int unsigned BW_FIELD_MAX  = 2000000;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY
  } stall_mode_e;

  typedef struct packed {
    logic [SF_W-1:0]   sf;
    logic [BW_W-1:0]   bw;
    logic              wide;
    logic [UTIL_W-1:0] util;
    logic [SNR_W-1:0]  snr;
    logic              router;
    logic [WORD_W-1:0] own_word;
    logic [WORD_W-1:0] relay_word;
  } request_t;

  logic                  clk_i     = 1'b0;
  logic                  rst_ni    = 1'b0;
  logic                  in_valid  = 1'b0;
  request_t              req       = '0;
  logic                  out_ready = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  logic                  in_ready;
  logic                  out_valid;
  logic                  cfg_ready;
  logic [SLOT_W-1:0]     slot_ms;
  logic [EXP_W-1:0]      own_window_exp;
  logic [EXP_W-1:0]      relay_window_exp;
  logic [DELAY_W-1:0]    own_delay_ms;
  logic [DELAY_W-1:0]    relay_delay_ms;
  logic [DELAY_W-1:0]    relay_worst_ms;

  int unsigned           fail_count;
  int unsigned           outstanding;
  int unsigned           burst_left = 0;
  int unsigned           cycles     = 0;
  stall_mode_e           stall_mode = STALL_NONE;
  int unsigned           stall_left = 0;

  radio_contention_backoff_delay u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready),
    .spread_factor_i    (req.sf),
    .bandwidth_hz_i     (req.bw),
    .wide_band_i        (req.wide),
    .utilisation_pct_i  (req.util),
    .link_snr_i         (req.snr),
    .router_like_i      (req.router),
    .own_random_i       (req.own_word),
    .relay_random_i     (req.relay_word),
    .out_valid_o        (out_valid),
    .out_ready_i        (out_ready),
    .slot_ms_o          (slot_ms),
    .own_window_exp_o   (own_window_exp),
    .relay_window_exp_o (relay_window_exp),
    .own_delay_ms_o     (own_delay_ms),
    .relay_delay_ms_o   (relay_delay_ms),
    .relay_worst_ms_o   (relay_worst_ms),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_o        (cfg_ready),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data)
  );

  rcbd_checker u_checker (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid),
    .in_ready_i         (in_ready),
    .spread_factor_i    (req.sf),
    .bandwidth_hz_i     (req.bw),
    .wide_band_i        (req.wide),
    .utilisation_pct_i  (req.util),
    .link_snr_i         (req.snr),
    .router_like_i      (req.router),
    .own_random_i       (req.own_word),
    .relay_random_i     (req.relay_word),
    .out_valid_i        (out_valid),
    .out_ready_i        (out_ready),
    .slot_ms_i          (slot_ms),
    .own_window_exp_i   (own_window_exp),
    .relay_window_exp_i (relay_window_exp),
    .own_delay_ms_i     (own_delay_ms),
    .relay_delay_ms_i   (relay_delay_ms),
    .relay_worst_ms_i   (relay_worst_ms),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_i        (cfg_ready),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data),
    .fail_count_o       (fail_count),
    .outstanding_o      (outstanding)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode <= stall_mode_e'($urandom_range(0, 2));
      stall_left <= $urandom_range(40, 300);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      STALL_NONE: begin
        out_ready <= 1'b1;
      end
      STALL_LIGHT: begin
        out_ready <= ($urandom_range(0, 3) != 0);
      end
      default: begin
        out_ready <= ($urandom_range(0, 5) == 0);
      end
    endcase
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("radio_contention_backoff_delay_tb failed");
      $finish;
    end
  end

  function automatic request_t req_of(input int unsigned sf, input int unsigned bw,
                                      input int unsigned wide, input int unsigned util,
                                      input int snr, input int unsigned router,
                                      input logic [WORD_W-1:0] own_word,
                                      input logic [WORD_W-1:0] relay_word);
    request_t r;
    r.sf         = SF_W'(sf);
    r.bw         = BW_W'(bw);
    r.wide       = wide[0];
    r.util       = UTIL_W'(util);
    r.snr        = snr[SNR_W-1:0];
    r.router     = router[0];
    r.own_word   = own_word;
    r.relay_word = relay_word;
    return r;
  endfunction

  function automatic request_t random_request();
    request_t r;
    int       snr;
    if ($urandom_range(0, 9) < 7) begin
      r.sf = SF_W'($urandom_range(1, MAX_SPREAD_FACTOR));
    end else begin
      r.sf = SF_W'($urandom);
    end
    case ($urandom_range(0, 9))
      0: begin
        r.bw = BW_W'($urandom);
      end
      1: begin
        r.bw = BW_W'($urandom_range(0, 3000));
      end
      2, 3: begin
        r.bw = BW_W'($urandom_range(0, BW_FIELD_MAX));
      end
      default: begin
        case ($urandom_range(0, 6))
          0:       r.bw = BW_W'(125000);
          1:       r.bw = BW_W'(250000);
          2:       r.bw = BW_W'(500000);
          3:       r.bw = BW_W'(203125);
          4:       r.bw = BW_W'(406250);
          5:       r.bw = BW_W'(812500);
          default: r.bw = BW_W'(1625000);
        endcase
      end
    endcase
    r.wide = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 3) != 0) begin
      r.util = UTIL_W'($urandom_range(0, 110));
    end else begin
      r.util = UTIL_W'($urandom);
    end
    if ($urandom_range(0, 3) != 0) begin
      snr = int'($urandom_range(0, 40)) - 25;
    end else begin
      snr = int'($urandom_range(0, 255)) - 128;
    end
    r.snr        = snr[SNR_W-1:0];
    r.router     = 1'($urandom_range(0, 1));
    r.own_word   = $urandom;
    r.relay_word = $urandom;
    return r;
  endfunction

  // The sender works in bursts; valid drops between bursts and while results are drained.
  task automatic send_req(input request_t r);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? 160 : $urandom_range(1, 24);
    end
    burst_left--;
    in_valid <= 1'b1;
    req      <= r;
    do @(posedge clk_i); while (!in_ready);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
  endtask

  // Unused upper data bits carry noise; an unmapped index is written once per setting.
  task automatic set_config(input logic [EXP_W-1:0] lo, input logic [EXP_W-1:0] hi,
                            input logic [MULT_W-1:0] mult, input logic [OVR_W-1:0] ovr);
    logic                  stray_first;
    logic [CFG_DATA_W-1:0] noise;
    stray_first = $urandom_range(0, 1);
    noise       = CFG_DATA_W'($urandom);
    drain_results();
    if (stray_first) begin
      write_reg(CFG_IDX_W'($urandom_range(REG_COUNT, 2**CFG_IDX_W - 1)), CFG_DATA_W'($urandom));
    end
    write_reg(REG_WINDOW_MIN, {noise[CFG_DATA_W-1:EXP_W], lo});
    write_reg(REG_WINDOW_MAX, {noise[EXP_W-1:0], noise[CFG_DATA_W-1:2*EXP_W], hi});
    write_reg(REG_RELAY_MULT, {noise[CFG_DATA_W-1:MULT_W], mult});
    write_reg(REG_SLOT_OVR, CFG_DATA_W'(ovr));
    if (!stray_first) begin
      write_reg(CFG_IDX_W'($urandom_range(REG_COUNT, 2**CFG_IDX_W - 1)), CFG_DATA_W'($urandom));
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic run_directed();
    send_req(req_of(0, 125000, 0, 0, 0, 0, '0, '0));
    send_req(req_of(1, 125000, 0, 100, -20, 0, '1, '1));
    send_req(req_of(20, 1000, 1, 50, 10, 1, '1, '1));
    send_req(req_of(21, 500000, 1, 30, 0, 0, '1, '1));
    send_req(req_of(31, 2097151, 0, 255, 127, 0, '1, '0));
    send_req(req_of(7, 999, 0, 60, -3, 0, '1, '1));
    send_req(req_of(7, 0, 1, 60, -3, 1, '1, '1));
    send_req(req_of(12, 2097151, 1, 101, -128, 1, '1, '1));
    send_req(req_of(14, 812500, 1, 75, -21, 0, 32'h1234_5678, 32'h8765_4321));
    send_req(req_of(15, 812500, 1, 25, 11, 0, 32'hDEAD_BEEF, 32'hCAFE_F00D));
    send_req(req_of(9, 125000, 0, 99, 9, 1, 32'h0000_7FFF, 32'h0000_00FF));
    send_req(req_of(11, 250000, 0, 1, -19, 1, '1, 32'hA5A5_A5A5));
    send_req(req_of(10, 1000, 0, 12, -5, 0, '1, '1));
    send_req(req_of(20, 1999, 0, 100, 10, 0, '1, '1));
    send_req(req_of(16, 2000000, 1, 37, 3, 1, 32'h5555_5555, 32'hAAAA_AAAA));
    send_req(req_of(8, 62500, 0, 64, -11, 0, 32'hFFFF_0000, 32'h0000_FFFF));
    send_req(req_of(5, 1000000, 1, 0, -20, 1, '0, '1));
    send_req(req_of(6, 1625000, 0, 200, -100, 0, '1, '0));
  endtask

  task automatic run_random(input int unsigned count);
    repeat (count) begin
      if ($urandom_range(0, 199) == 0) drain_results();
      send_req(random_request());
    end
  endtask

  initial begin
    int unsigned phase;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    set_config(EXP_W'(0), EXP_W'(15), MULT_W'(255), OVR_W'(0));
    run_random(PHASE_ITEMS);
    set_config(EXP_W'(15), EXP_W'(0), MULT_W'(0), OVR_W'(65535));
    run_random(PHASE_ITEMS);
    set_config(EXP_W'(0), EXP_W'(0), MULT_W'(200), OVR_W'(0));
    run_random(PHASE_ITEMS);
    set_config(EXP_W'(15), EXP_W'(15), MULT_W'(255), OVR_W'(65535));
    run_random(PHASE_ITEMS);
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      set_config(EXP_W'($urandom), EXP_W'($urandom), MULT_W'($urandom),
                 ($urandom_range(0, 1) == 0) ? OVR_W'(0) :
                 ($urandom_range(0, 1) == 0) ? OVR_W'($urandom_range(1, 500)) :
                                               OVR_W'($urandom_range(1, 65535)));
      run_random(PHASE_ITEMS);
    end
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && outstanding == 0) begin
      $display("radio_contention_backoff_delay_tb passed");
    end else begin
      $display("radio_contention_backoff_delay_tb failed");
    end
    $finish;
  end

endmodule
